/* sv/socd_pkg.sv */
// ----------------------------------------------------------------------------
// socd_pkg
// Shared types and constants for the analog axis SOCD resolver.
// ----------------------------------------------------------------------------
`default_nettype none

package socd_pkg;

  localparam int AXIS_COUNT_DEF = 4;

  localparam int TRAVEL_W = 15;
  localparam int STICK_W  = 16;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef logic [TRAVEL_W-1:0]       travel_t;
  typedef logic signed [STICK_W-1:0] stick_t;

  // Fixed-point thresholds, 32767 == 1.0
  localparam travel_t PRESS_THRESHOLD = 15'd3277;   // 0.10
  localparam travel_t IDLE_LIMIT      = 15'd3;      // 0.0001
  localparam travel_t EQUAL_LIMIT     = 15'd65;     // 0.002
  localparam travel_t DELTA_MIN       = 15'd655;    // 0.02
  localparam travel_t DELTA_MAX       = 15'd31129;  // 0.95
  localparam travel_t FULL_TRAVEL     = 15'd32767;
  localparam travel_t DELTA_RESET     = 15'd9830;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_PLUS  = 2'd1,
    DIR_MINUS = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    REG_SNAPPY = 2'd0,
    REG_LKP    = 2'd1,
    REG_DELTA  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic    snappy;
    logic    lkp;
    travel_t delta;
  } cfg_t;

  typedef struct packed {
    logic    minus_down;
    logic    plus_down;
    dir_t    dir;
    travel_t minus_valley;
    travel_t plus_valley;
  } axis_state_t;

  localparam axis_state_t AXIS_STATE_RESET = '{
    minus_down:   1'b0,
    plus_down:    1'b0,
    dir:          DIR_NONE,
    minus_valley: FULL_TRAVEL,
    plus_valley:  FULL_TRAVEL
  };

endpackage

`default_nettype wire

/* sv/socd_chan_if.sv */
// ----------------------------------------------------------------------------
// socd channel interfaces
// Valid/ready channels for key travel beats in and stick value beats out.
// ----------------------------------------------------------------------------
`default_nettype none

interface socd_in_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           axis_index;
  socd_pkg::travel_t    minus_travel;
  socd_pkg::travel_t    plus_travel;

  modport source (output valid, output axis_index, output minus_travel,
                  output plus_travel, input ready);
  modport sink   (input valid, input axis_index, input minus_travel,
                  input plus_travel, output ready);
endinterface

interface socd_out_if;
  logic                 valid;
  logic                 ready;
  socd_pkg::stick_t     stick_value;

  modport source (output valid, output stick_value, input ready);
  modport sink   (input valid, input stick_value, output ready);
endinterface

`default_nettype wire

/* sv/socd_cfg.sv */
// ----------------------------------------------------------------------------
// socd_cfg
// APB register file: snappy mode, last-key priority, retrigger delta.
// ----------------------------------------------------------------------------
`default_nettype none

module socd_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [socd_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [socd_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output      logic [socd_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output      logic                               cfg_pready,
  output      socd_pkg::cfg_t                     cfg
);

  socd_pkg::cfg_t cfg_r, cfg_nxt;
  logic [1:0]     reg_sel;
  logic           wr_en;

  assign reg_sel    = cfg_paddr[3:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        socd_pkg::REG_SNAPPY: cfg_nxt.snappy = cfg_pwdata[0];
        socd_pkg::REG_LKP:    cfg_nxt.lkp    = cfg_pwdata[0];
        socd_pkg::REG_DELTA:  cfg_nxt.delta  = cfg_pwdata[socd_pkg::TRAVEL_W-1:0];
        default: ;  // unmapped, ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      socd_pkg::REG_SNAPPY: cfg_prdata = {{(socd_pkg::CFG_DATA_W-1){1'b0}}, cfg_r.snappy};
      socd_pkg::REG_LKP:    cfg_prdata = {{(socd_pkg::CFG_DATA_W-1){1'b0}}, cfg_r.lkp};
      socd_pkg::REG_DELTA:  cfg_prdata = {{(socd_pkg::CFG_DATA_W-socd_pkg::TRAVEL_W){1'b0}},
                                          cfg_r.delta};
      default:              cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.snappy <= 1'b0;
      cfg_r.lkp    <= 1'b0;
      cfg_r.delta  <= socd_pkg::DELTA_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

/* sv/socd_resolve.sv */
// ----------------------------------------------------------------------------
// socd_resolve
// Combinational resolver: one item plus its axis entry gives the stick
// value and the updated axis entry.
// ----------------------------------------------------------------------------
`default_nettype none

module socd_resolve (
  input  wire socd_pkg::cfg_t         cfg,
  input  wire socd_pkg::axis_state_t  cur,
  input  wire socd_pkg::travel_t      mv,
  input  wire socd_pkg::travel_t      pv,
  output      socd_pkg::axis_state_t  nxt,
  output      socd_pkg::stick_t       stick_value
);

  logic              mdown, pdown, m_edge, p_edge;
  socd_pkg::travel_t delta, maximum, m_valley, p_valley;
  socd_pkg::dir_t    dir_a, dir_b, dir_c, dir_win;
  logic [15:0]       diff;       // pv - mv, signed 16 bit
  socd_pkg::stick_t  s_max, s_neg_max, s_pv, s_neg_mv, s_mag;

  assign mdown   = mv >= socd_pkg::PRESS_THRESHOLD;
  assign pdown   = pv >= socd_pkg::PRESS_THRESHOLD;
  assign m_edge  = mdown && !cur.minus_down;
  assign p_edge  = pdown && !cur.plus_down;
  assign maximum = (mv > pv) ? mv : pv;
  assign diff    = {1'b0, pv} - {1'b0, mv};

  assign s_max     = socd_pkg::stick_t'({1'b0, maximum});
  assign s_neg_max = -s_max;
  assign s_pv      = socd_pkg::stick_t'({1'b0, pv});
  assign s_neg_mv  = -socd_pkg::stick_t'({1'b0, mv});

  // Retrigger delta saturated to its legal range
  always_comb begin
    if (cfg.delta < socd_pkg::DELTA_MIN)      delta = socd_pkg::DELTA_MIN;
    else if (cfg.delta > socd_pkg::DELTA_MAX) delta = socd_pkg::DELTA_MAX;
    else                                      delta = cfg.delta;
  end

  // Press edges, then minus valley, then plus valley; later steps override dir
  always_comb begin
    dir_a = cur.dir;
    if (m_edge) dir_a = socd_pkg::DIR_MINUS;
    if (p_edge) dir_a = socd_pkg::DIR_PLUS;

    dir_b    = dir_a;
    m_valley = cur.minus_valley;
    if (cfg.lkp) begin
      if (!mdown) begin
        m_valley = socd_pkg::FULL_TRAVEL;
      end else if (!cur.minus_down) begin
        m_valley = mv;
      end else if (mv < cur.minus_valley) begin
        m_valley = mv;
      end else if ((mv - cur.minus_valley) >= delta) begin
        m_valley = mv;
        dir_b    = socd_pkg::DIR_MINUS;
      end
    end

    dir_c    = dir_b;
    p_valley = cur.plus_valley;
    if (cfg.lkp) begin
      if (!pdown) begin
        p_valley = socd_pkg::FULL_TRAVEL;
      end else if (!cur.plus_down) begin
        p_valley = pv;
      end else if (pv < cur.plus_valley) begin
        p_valley = pv;
      end else if ((pv - cur.plus_valley) >= delta) begin
        p_valley = pv;
        dir_c    = socd_pkg::DIR_PLUS;
      end
    end
  end

  // Both held under priority: recorded direction, else the deeper key
  always_comb begin
    if (dir_c == socd_pkg::DIR_PLUS || dir_c == socd_pkg::DIR_MINUS) begin
      dir_win = dir_c;
    end else begin
      dir_win = (pv >= mv) ? socd_pkg::DIR_PLUS : socd_pkg::DIR_MINUS;
    end
    if (cfg.snappy) s_mag = s_max;
    else            s_mag = (dir_win == socd_pkg::DIR_PLUS) ? s_pv : -socd_pkg::stick_t'({1'b0, mv});
  end

  always_comb begin
    if (!cfg.snappy && !cfg.lkp) begin
      nxt = cur;
    end else begin
      nxt.minus_down   = mdown;
      nxt.plus_down    = pdown;
      nxt.dir          = dir_c;
      nxt.minus_valley = m_valley;
      nxt.plus_valley  = p_valley;
    end
  end

  always_comb begin
    priority if (!cfg.snappy && !cfg.lkp) begin
      stick_value = socd_pkg::stick_t'(diff);
    end else if (maximum <= socd_pkg::IDLE_LIMIT) begin
      stick_value = '0;
    end else if (cfg.lkp && mdown && !pdown) begin
      stick_value = s_neg_mv;
    end else if (cfg.lkp && pdown && !mdown) begin
      stick_value = s_pv;
    end else if (cfg.lkp && pdown && mdown) begin
      stick_value = (dir_win == socd_pkg::DIR_PLUS || cfg.snappy == 1'b0) ? s_mag : -s_mag;
    end else if (cfg.snappy) begin
      if ($signed(diff) > $signed({1'b0, socd_pkg::EQUAL_LIMIT})) begin
        stick_value = s_max;
      end else if ($signed(diff) < -$signed({1'b0, socd_pkg::EQUAL_LIMIT})) begin
        stick_value = s_neg_max;
      end else if (dir_c == socd_pkg::DIR_PLUS) begin
        stick_value = s_max;
      end else if (dir_c == socd_pkg::DIR_MINUS) begin
        stick_value = s_neg_max;
      end else begin
        stick_value = '0;
      end
    end else begin
      stick_value = socd_pkg::stick_t'(diff);
    end
  end

endmodule

`default_nettype wire

/* sv/analog_axis_socd_resolver_unit.sv */
// ----------------------------------------------------------------------------
// analog_axis_socd_resolver_unit
// Resolves opposite analog key travels of one stick axis into a signed value.
// ----------------------------------------------------------------------------
// Path: an accepted input beat is held in the input register, then in the
//   result register, which offers the result beat; an output stall holds it.
// Throughput: 1 beat per cycle while out_chan.ready holds; the per-axis
//   state is read and rewritten in the single resolve stage, so back-to-back
//   beats on one axis chain cleanly.
// Reset: synchronous, active low; clears both stages, config to defaults and
//   every axis entry to released keys, no direction, valleys at full travel.
// ----------------------------------------------------------------------------
`default_nettype none

module analog_axis_socd_resolver_unit #(
  parameter int AXIS_COUNT = socd_pkg::AXIS_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  socd_in_if.sink                               in_chan,
  socd_out_if.source                            out_chan,
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [socd_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [socd_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output      logic [socd_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output      logic                             cfg_pready
);

  localparam int AXIS_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

  // Axis field is 2 bits; fold it onto the table when the table is smaller.
  function automatic logic [AXIS_W-1:0] axis_slot(input logic [1:0] idx);
    logic [1:0] v;
    v = idx;
    for (int k = 0; k < 3; k++) begin
      if (int'(v) >= AXIS_COUNT) v = v - 2'(AXIS_COUNT);
    end
    return AXIS_W'(v);
  endfunction

  socd_pkg::cfg_t cfg;

  socd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Input stage
  logic               s1_valid_r, s1_valid_nxt;
  logic [AXIS_W-1:0]  s1_slot_r;
  socd_pkg::travel_t  s1_mv_r, s1_pv_r;

  // Result stage
  logic               out_valid_r, out_valid_nxt;
  socd_pkg::stick_t   out_value_r;

  logic in_fire, advance;

  // Stage 1 moves into the result register whenever that register is free
  // or being drained this cycle; input is taken whenever stage 1 empties.
  assign advance       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || advance;
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign s1_valid_nxt  = in_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);

  assign out_chan.valid       = out_valid_r;
  assign out_chan.stick_value = out_value_r;

  // Per-axis key state
  socd_pkg::axis_state_t axis_r [AXIS_COUNT];
  socd_pkg::axis_state_t cur_entry, nxt_entry;
  socd_pkg::stick_t      stick_nxt;

  assign cur_entry = axis_r[s1_slot_r];

  socd_resolve u_resolve (
    .cfg         (cfg),
    .cur         (cur_entry),
    .mv          (s1_mv_r),
    .pv          (s1_pv_r),
    .nxt         (nxt_entry),
    .stick_value (stick_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_slot_r <= axis_slot(in_chan.axis_index);
      s1_mv_r   <= in_chan.minus_travel;
      s1_pv_r   <= in_chan.plus_travel;
    end
    if (advance) begin
      out_value_r <= stick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        axis_r[i] <= socd_pkg::AXIS_STATE_RESET;
      end
    end else if (advance) begin
      axis_r[s1_slot_r] <= nxt_entry;
    end
  end

endmodule

`default_nettype wire
